>>> design/fpba_pkg.sv
package fpba_pkg;

  localparam int MAX_BLOCKS_DEF = 16;

  localparam int CMD_W      = 2;
  localparam int SIZE_W     = 16;
  localparam int ST_W       = 2;
  localparam int BIDX_W     = 4;
  localparam int CNT_CFG_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CNT_CFG_W-1:0] RST_BLOCK_COUNT = 5'd8;
  localparam logic [SIZE_W-1:0]    RST_FIRST_SIZE  = 16'd1000;
  localparam logic [SIZE_W-1:0]    RST_SIZE_STEP   = 16'd100;

  typedef enum logic [CMD_W-1:0] {
    CMD_FIRST  = 2'd0,
    CMD_BEST   = 2'd1,
    CMD_WORST  = 2'd2,
    CMD_REINIT = 2'd3
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_GRANTED = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_REINIT  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_COUNT = 2'd0,
    REG_FIRST_SIZE  = 2'd1,
    REG_SIZE_STEP   = 2'd2
  } cfg_reg_t;

  // best candidate so far, handed from cell to cell
  typedef struct packed {
    logic              found;
    logic [SIZE_W-1:0] free_amt;
    logic [SIZE_W-1:0] alloc_amt;
  } cand_t;

  // table update broadcast to all cells
  typedef struct packed {
    logic              reinit;
    logic              grant;
    logic [SIZE_W-1:0] size;
  } upd_t;

  // free amount of block i after reset: first size minus i times step, floor at 0
  function automatic logic [SIZE_W-1:0] rst_free(input int i);
    longint dec;
    dec = longint'(i) * longint'(RST_SIZE_STEP);
    if (dec >= longint'(RST_FIRST_SIZE)) return '0;
    return SIZE_W'(longint'(RST_FIRST_SIZE) - dec);
  endfunction

endpackage

>>> design/fpba_ifs.sv
interface fpba_in_if;
  logic                        valid;
  logic                        ready;
  logic [fpba_pkg::CMD_W-1:0]  cmd;
  logic [fpba_pkg::SIZE_W-1:0] request_size;

  modport source (output valid, output cmd, output request_size, input ready);
  modport sink   (input valid, input cmd, input request_size, output ready);
endinterface

interface fpba_out_if;
  logic                        valid;
  logic                        ready;
  logic [fpba_pkg::ST_W-1:0]   status;
  logic [fpba_pkg::BIDX_W-1:0] block_index;
  logic [fpba_pkg::SIZE_W-1:0] remaining_free;
  logic [fpba_pkg::SIZE_W-1:0] allocated_total;

  modport source (output valid, output status, output block_index,
                  output remaining_free, output allocated_total, input ready);
  modport sink   (input valid, input status, input block_index,
                  input remaining_free, input allocated_total, output ready);
endinterface

interface fpba_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fpba_pkg::CFG_IDX_W-1:0]  index;
  logic [fpba_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/fpba_cell.sv
module fpba_cell #(
  parameter int IDX    = 0,
  parameter int IDX_W  = 4,
  parameter int NW     = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [NW-1:0]               n_eff,
  input  fpba_pkg::cmd_t              cmd,
  input  logic [fpba_pkg::SIZE_W-1:0] req_size,
  input  logic [fpba_pkg::SIZE_W-1:0] step,
  input  logic [fpba_pkg::SIZE_W-1:0] init_in,
  output logic [fpba_pkg::SIZE_W-1:0] init_out_r,
  input  fpba_pkg::cand_t             cand_in,
  input  logic [IDX_W-1:0]            cand_in_idx,
  output fpba_pkg::cand_t             cand_out_r,
  output logic [IDX_W-1:0]            cand_out_idx_r,
  input  fpba_pkg::upd_t              upd,
  input  logic [IDX_W-1:0]            upd_idx
);
  import fpba_pkg::*;

  localparam logic [SIZE_W-1:0] FREE_RST = rst_free(IDX);
  localparam logic [IDX_W-1:0]  MY_IDX   = IDX_W'(IDX);

  logic [SIZE_W-1:0] free_r, free_nxt;
  logic [SIZE_W-1:0] alloc_r, alloc_nxt;
  logic              active, fits, take;
  cand_t             cand_nxt;
  logic [IDX_W-1:0]  cand_idx_nxt;
  logic [SIZE_W-1:0] init_nxt;

  assign active = (n_eff > NW'(IDX));
  assign fits   = active && (free_r >= req_size);

  always_comb begin
    take = 1'b0;
    case (cmd)
      CMD_FIRST: take = fits && !cand_in.found;
      CMD_BEST:  take = fits && (!cand_in.found || free_r <= cand_in.free_amt);
      CMD_WORST: take = fits && (!cand_in.found || free_r >= cand_in.free_amt);
      default:   take = 1'b0;
    endcase
  end

  always_comb begin
    cand_nxt     = cand_in;
    cand_idx_nxt = cand_in_idx;
    if (take) begin
      cand_nxt.found     = 1'b1;
      cand_nxt.free_amt  = free_r;
      cand_nxt.alloc_amt = alloc_r;
      cand_idx_nxt       = MY_IDX;
    end
  end

  // saturating subtract; chained over cells this gives first - i*step floored at 0
  assign init_nxt = (init_in > step) ? (init_in - step) : '0;

  always_comb begin
    free_nxt  = free_r;
    alloc_nxt = alloc_r;
    if (upd.reinit) begin
      free_nxt  = init_in;
      alloc_nxt = '0;
    end else if (upd.grant && upd_idx == MY_IDX) begin
      free_nxt  = free_r - upd.size;
      alloc_nxt = alloc_r + upd.size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r  <= FREE_RST;
      alloc_r <= '0;
    end else begin
      free_r  <= free_nxt;
      alloc_r <= alloc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_out_r     <= cand_nxt;
    cand_out_idx_r <= cand_idx_nxt;
    init_out_r     <= init_nxt;
  end

endmodule

>>> design/fit_policy_block_allocator.sv
// Block allocator with first, best and worst fit policies.
// Channels: in_ch takes a word of {cmd, request_size}; out_ch returns one word
// of {status, block_index, remaining_free, allocated_total} per input word;
// cfg_ch writes block_count, first_block_size and size_step (always ready).
// Write configuration only while the block is idle.
// The table sits in a row of MAX_BLOCKS cells. A candidate record walks down
// the row one cell per cycle, each cell replacing it when its own block is a
// better pick; a reload value walks down the same way for reinitialize.
// The walk over the row of cells runs in S_SCAN; S_UPD then commits the table
// update and loads the result. One word is in work at a time and the block
// returns to the idle state before taking the next word.
// The result waits in an output register; the next word is accepted while it
// waits, but its table update and result hold until out_ch takes the old one.
// Reset: registers return to 8 / 1000 / 100 and block i holds
// 1000 - 100*i (floor 0) free, 0 allocated; ready for a word right after reset.
module fit_policy_block_allocator #(
  parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  fpba_in_if.sink    in_ch,
  fpba_out_if.source out_ch,
  fpba_cfg_if.sink   cfg_ch
);
  import fpba_pkg::*;

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int NW    = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       cnt_r, cnt_nxt;
  cmd_t                   cmd_r;
  logic [SIZE_W-1:0]      size_r;
  logic [CNT_CFG_W-1:0]   block_count_r;
  logic [SIZE_W-1:0]      first_size_r;
  logic [SIZE_W-1:0]      step_r;
  logic [NW-1:0]          n_eff;

  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r;
  logic [BIDX_W-1:0]      out_idx_r;
  logic [SIZE_W-1:0]      out_free_r;
  logic [SIZE_W-1:0]      out_alloc_r;

  logic                   in_fire, commit;
  upd_t                   upd;
  cand_t                  last_cand;
  logic [IDX_W-1:0]       last_idx;
  logic [31:0]            last_idx_ext;

  cand_t                  cand   [MAX_BLOCKS+1];
  logic [IDX_W-1:0]       cidx   [MAX_BLOCKS+1];
  logic [SIZE_W-1:0]      init_c [MAX_BLOCKS+1];

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    if (block_count_r == '0)
      n_eff = NW'(1);
    else if (32'(block_count_r) > 32'(MAX_BLOCKS))
      n_eff = NW'(MAX_BLOCKS);
    else
      n_eff = NW'(block_count_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= RST_BLOCK_COUNT;
      first_size_r  <= RST_FIRST_SIZE;
      step_r        <= RST_SIZE_STEP;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_BLOCK_COUNT: block_count_r <= cfg_ch.data[CNT_CFG_W-1:0];
        REG_FIRST_SIZE:  first_size_r  <= cfg_ch.data[SIZE_W-1:0];
        REG_SIZE_STEP:   step_r        <= cfg_ch.data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // row of cells
  assign cand[0]   = '0;
  assign cidx[0]   = '0;
  assign init_c[0] = first_size_r;

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    fpba_cell #(
      .IDX   (g),
      .IDX_W (IDX_W),
      .NW    (NW)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .n_eff          (n_eff),
      .cmd            (cmd_r),
      .req_size       (size_r),
      .step           (step_r),
      .init_in        (init_c[g]),
      .init_out_r     (init_c[g+1]),
      .cand_in        (cand[g]),
      .cand_in_idx    (cidx[g]),
      .cand_out_r     (cand[g+1]),
      .cand_out_idx_r (cidx[g+1]),
      .upd            (upd),
      .upd_idx        (cidx[MAX_BLOCKS])
    );
  end

  assign last_cand    = cand[MAX_BLOCKS];
  assign last_idx     = cidx[MAX_BLOCKS];
  assign last_idx_ext = 32'(last_idx);

  // result may only be written once the previous one is gone
  assign commit = (state_r == S_UPD) && (!out_valid_r || out_ch.ready);

  always_comb begin
    upd        = '0;
    upd.size   = size_r;
    if (commit) begin
      upd.reinit = (cmd_r == CMD_REINIT);
      upd.grant  = (cmd_r != CMD_REINIT) && last_cand.found;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_fire) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == IDX_W'(MAX_BLOCKS - 1)) state_nxt = S_UPD;
      end
      S_UPD: begin
        if (commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    if (commit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= cmd_t'(in_ch.cmd);
      size_r <= in_ch.request_size;
    end
    if (commit) begin
      if (cmd_r == CMD_REINIT) begin
        out_status_r <= ST_REINIT;
        out_idx_r    <= '0;
        out_free_r   <= '0;
        out_alloc_r  <= '0;
      end else if (last_cand.found) begin
        out_status_r <= ST_GRANTED;
        out_idx_r    <= last_idx_ext[BIDX_W-1:0];
        out_free_r   <= last_cand.free_amt - size_r;
        out_alloc_r  <= last_cand.alloc_amt + size_r;
      end else begin
        out_status_r <= ST_NOFIT;
        out_idx_r    <= '0;
        out_free_r   <= '0;
        out_alloc_r  <= '0;
      end
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.block_index     = out_idx_r;
  assign out_ch.remaining_free  = out_free_r;
  assign out_ch.allocated_total = out_alloc_r;

endmodule

>>> test/fpba_checker.sv
`timescale 1ns / 100ps
module fpba_checker (
  input  logic clk,
  input  logic rst_n,
  fpba_in_if   in_ch,
  fpba_out_if  out_ch,
  fpba_cfg_if  cfg_ch,
  output int   errors,
  output int   outstanding,
  output int   granted,
  output int   refused,
  output int   reloads
);
  import fpba_pkg::*;

  typedef struct packed {
    status_t           status;
    logic [BIDX_W-1:0] block_index;
    logic [SIZE_W-1:0] remaining_free;
    logic [SIZE_W-1:0] allocated_total;
  } reply_t;

  logic [CNT_CFG_W-1:0] blk_count;
  logic [SIZE_W-1:0]    base_size;
  logic [SIZE_W-1:0]    stride;
  logic [SIZE_W-1:0]    free_amt  [MAX_BLOCKS_DEF];
  logic [SIZE_W-1:0]    alloc_amt [MAX_BLOCKS_DEF];
  reply_t               replies_due [$];

  // all entries reload, in use or not
  function automatic void reload_table();
    longint dec;
    for (int i = 0; i < MAX_BLOCKS_DEF; i++) begin
      dec = longint'(i) * longint'(stride);
      free_amt[i]  = (dec >= longint'(base_size)) ? '0 : SIZE_W'(longint'(base_size) - dec);
      alloc_amt[i] = '0;
    end
  endfunction

  function automatic reply_t predict_allocation(cmd_t op, logic [SIZE_W-1:0] req);
    reply_t r;
    int     n;
    int     pick;
    bit     found;
    r = '0;
    if (op == CMD_REINIT) begin
      reload_table();
      r.status = ST_REINIT;
      reloads++;
      return r;
    end
    n = int'(blk_count);
    if (n == 0) n = 1;
    if (n > MAX_BLOCKS_DEF) n = MAX_BLOCKS_DEF;
    pick  = 0;
    found = 0;
    for (int i = 0; i < n; i++) begin
      if (free_amt[i] < req) continue;
      if (op == CMD_FIRST) begin
        pick  = i;
        found = 1;
        break;
      end
      // ties go to the later block
      if (!found || (op == CMD_BEST && free_amt[i] <= free_amt[pick]) ||
          (op == CMD_WORST && free_amt[i] >= free_amt[pick])) begin
        pick  = i;
        found = 1;
      end
    end
    if (!found) begin
      r.status = ST_NOFIT;
      refused++;
      return r;
    end
    free_amt[pick]    = free_amt[pick] - req;
    alloc_amt[pick]   = alloc_amt[pick] + req;
    r.status          = ST_GRANTED;
    r.block_index     = BIDX_W'(pick);
    r.remaining_free  = free_amt[pick];
    r.allocated_total = alloc_amt[pick];
    granted++;
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (!rst_n) begin
      blk_count = RST_BLOCK_COUNT;
      base_size = RST_FIRST_SIZE;
      stride    = RST_SIZE_STEP;
      reload_table();
      replies_due.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.index))
          REG_BLOCK_COUNT: blk_count = cfg_ch.data[CNT_CFG_W-1:0];
          REG_FIRST_SIZE:  base_size = cfg_ch.data;
          REG_SIZE_STEP:   stride    = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        replies_due.push_back(predict_allocation(cmd_t'(in_ch.cmd), in_ch.request_size));
      if (out_ch.valid && out_ch.ready) begin
        got.status          = status_t'(out_ch.status);
        got.block_index     = out_ch.block_index;
        got.remaining_free  = out_ch.remaining_free;
        got.allocated_total = out_ch.allocated_total;
        if (replies_due.size() == 0) begin
          $error("unexpected result word: status %0d block %0d free %0d alloc %0d",
                 got.status, got.block_index, got.remaining_free, got.allocated_total);
          errors++;
        end else begin
          want = replies_due.pop_front();
          if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
          end
          if (got.block_index != want.block_index) begin
            $error("block_index: expected %0d, got %0d", want.block_index, got.block_index);
            errors++;
          end
          if (got.remaining_free != want.remaining_free) begin
            $error("remaining_free: expected %0d, got %0d",
                   want.remaining_free, got.remaining_free);
            errors++;
          end
          if (got.allocated_total != want.allocated_total) begin
            $error("allocated_total: expected %0d, got %0d",
                   want.allocated_total, got.allocated_total);
            errors++;
          end
        end
      end
    end
    outstanding = replies_due.size();
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import fpba_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 100;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  fpba_in_if  in_ch ();
  fpba_out_if out_ch ();
  fpba_cfg_if cfg_ch ();

  int errors, outstanding, granted, refused, reloads;
  int words_sent  = 0;
  int layouts     = 0;
  int cycles      = 0;
  int hold_requests = 0;
  int hold_len    = 0;
  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;
  logic [SIZE_W-1:0] cur_base;

  int phase_cnt    [PHASES] = '{1, 16, 16, 0, 31, 17, 5, 0};
  int phase_base   [PHASES] = '{500, 65535, 65535, 200, 4000, 0, 60000, 0};
  int phase_stride [PHASES] = '{0, 0, 65535, 10, 300, 5, 7000, 0};

  fit_policy_block_allocator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  fpba_checker alloc_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .errors      (errors),
    .outstanding (outstanding),
    .granted     (granted),
    .refused     (refused),
    .reloads     (reloads)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stalls, plus long hold-offs on request
  initial begin : receiver
    int hold_left;
    int served;
    hold_left    = 0;
    served       = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (served != hold_requests) begin
        served    = hold_requests;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(receiver_idles && $urandom_range(99) < 13);
      end
    end
  end

  // leaves valid high after the accepting edge; end_words drops it
  task automatic send_word(cmd_t op, logic [SIZE_W-1:0] req);
    @(negedge clk);
    while (sender_idles && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= op;
    in_ch.request_size <= req;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic end_words();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic set_layout(logic [CFG_DATA_W-1:0] cnt, logic [CFG_DATA_W-1:0] base,
                            logic [CFG_DATA_W-1:0] stride);
    cfg_reg_t              regs [3];
    logic [CFG_DATA_W-1:0] vals [3];
    regs = '{REG_BLOCK_COUNT, REG_FIRST_SIZE, REG_SIZE_STEP};
    vals = '{cnt, base, stride};
    for (int k = 0; k < 3; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= regs[k];
      cfg_ch.data  <= vals[k];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_ch.valid <= 1'b0;
    cur_base = base;
    layouts++;
  endtask

  // sizes cluster around the current block sizes so grants stay common
  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return SIZE_W'($urandom_range(16'hFFFF));
      4, 5:    return SIZE_W'($urandom_range(cur_base));
      default: return SIZE_W'($urandom_range(cur_base / 8));
    endcase
  endfunction

  task automatic send_random_word();
    cmd_t op;
    if ($urandom_range(99) < 8) op = CMD_REINIT;
    else op = cmd_t'($urandom_range(2));
    send_word(op, pick_size());
  endtask

  initial begin : stimulus
    in_ch.valid        = 1'b0;
    in_ch.cmd          = CMD_FIRST;
    in_ch.request_size = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_BLOCK_COUNT;
    cfg_ch.data        = '0;
    cur_base           = RST_FIRST_SIZE;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset table: 1000, 900, ... 300 free over eight blocks
    send_word(CMD_FIRST, '0);
    send_word(CMD_BEST, '0);
    send_word(CMD_WORST, '0);
    send_word(CMD_FIRST, '1);
    send_word(CMD_BEST, '1);
    send_word(CMD_WORST, '1);
    send_word(CMD_BEST, 16'd300);
    send_word(CMD_BEST, 16'd1);
    send_word(CMD_WORST, 16'd1000);
    send_word(CMD_FIRST, 16'd901);
    send_word(CMD_FIRST, 16'd900);
    send_word(CMD_REINIT, '1);
    send_word(CMD_WORST, 16'h8000);
    end_words();
    wait_drained();

    // zero step: all blocks equal, best and worst fit ties go to the last one
    set_layout(16'd8, 16'd1000, 16'd0);
    send_word(CMD_REINIT, '0);
    send_word(CMD_BEST, 16'd10);
    send_word(CMD_WORST, 16'd10);
    send_word(CMD_FIRST, 16'd10);
    end_words();
    wait_drained();

    // count zero acts as one block
    set_layout(16'd0, 16'd1000, 16'd0);
    send_word(CMD_WORST, '0);
    send_word(CMD_FIRST, 16'd2000);
    end_words();
    wait_drained();

    // count above the table size, upper entries unchanged without reload
    set_layout(16'd31, 16'd1000, 16'd0);
    send_word(CMD_BEST, 16'd5);
    send_word(CMD_REINIT, '0);
    end_words();
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1)
        set_layout(CFG_DATA_W'($urandom_range(1, MAX_BLOCKS_DEF)),
                   CFG_DATA_W'($urandom_range(16'hFFFF)),
                   CFG_DATA_W'($urandom_range(5000)));
      else
        set_layout(CFG_DATA_W'(phase_cnt[p]), CFG_DATA_W'(phase_base[p]),
                   CFG_DATA_W'(phase_stride[p]));
      if (p == 3) begin
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
      end
      // odd phases run on the stale table until a random reload
      if (p % 2 == 0) send_word(CMD_REINIT, SIZE_W'($urandom));
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (p == 5 && k == 10) begin
          hold_len = 400;
          hold_requests++;
        end
        send_random_word();
      end
      end_words();
      wait_drained();
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
    end

    repeat (MAX_BLOCKS_DEF + 10) @(posedge clk);

    $display("%0d words over %0d register layouts: %0d granted, %0d no fit, %0d reloads",
             words_sent, layouts, granted, refused, reloads);
    if (errors == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, outstanding);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
